// ===== rtl/core/mas_pkg.sv =====
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants
// Edge and vertex record layouts, handshake payloads and engine interface.
// ----------------------------------------------------------------------------
`default_nettype none

package mas_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 32768;

    localparam int VW = $clog2(MAX_VERTICES);  // vertex index bits
    localparam int EW = $clog2(MAX_EDGES);     // edge address bits
    localparam int CW = 24;                    // edge cost bits
    localparam int AW = 35;                    // weight accumulator bits
    localparam int OW = 34;                    // reported weight bits

    typedef logic [VW:0] vtag_t;               // vertex index or none marker

    localparam vtag_t NO_VERTEX = {1'b1, {VW{1'b0}}};

    typedef struct packed {
        logic [VW-1:0] src;
        logic [VW-1:0] dst;
        logic [CW-1:0] cost;
    } mas_edge_t;

    typedef struct packed {
        vtag_t         src;
        logic [CW-1:0] cost;
    } mas_vinfo_t;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  edge_from;
        logic [9:0]  edge_to;
        logic [23:0] edge_weight;
        logic [9:0]  root_vertex;
    } mas_in_t;

    typedef struct packed {
        logic [33:0] total_weight;
        logic        unreachable;
        logic        edges_dropped;
    } mas_out_t;

    typedef struct packed {
        logic          load;
        logic          run;
        logic          ack;
        mas_edge_t     edge_rec;
        logic [VW-1:0] root;
        logic [VW:0]   nv;
    } mas_cmd_t;

    typedef struct packed {
        logic     idle;
        logic     done;
        mas_out_t result;
    } mas_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mas_ram.sv =====
// ----------------------------------------------------------------------------
// mas_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mas_engine.sv =====
// ----------------------------------------------------------------------------
// mas_engine: edge store and Chu-Liu/Edmonds sequencer
// Stores loaded edges and runs rounds of min-in-edge selection, cycle
// contraction and edge reweighting over the RAMs with a shared accumulator adder.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_engine
    import mas_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire mas_cmd_t  cmd,
    output mas_stat_t      st
);

    typedef enum logic [20:0] {
        ST_IDLE     = 21'd1 << 0,
        ST_FILT_RD  = 21'd1 << 1,
        ST_FILT_WR  = 21'd1 << 2,
        ST_INIT     = 21'd1 << 3,
        ST_MIN_RD   = 21'd1 << 4,
        ST_MIN_VR   = 21'd1 << 5,
        ST_MIN_UP   = 21'd1 << 6,
        ST_WALK_RD  = 21'd1 << 7,
        ST_WALK_CHK = 21'd1 << 8,
        ST_STEP_RD  = 21'd1 << 9,
        ST_STEP_CHK = 21'd1 << 10,
        ST_CYC_RD   = 21'd1 << 11,
        ST_CYC_UP   = 21'd1 << 12,
        ST_CYC_END  = 21'd1 << 13,
        ST_REW_RD   = 21'd1 << 14,
        ST_REW_RB   = 21'd1 << 15,
        ST_REW_RA   = 21'd1 << 16,
        ST_REW_UP   = 21'd1 << 17,
        ST_COPY_RD  = 21'd1 << 18,
        ST_COPY_WR  = 21'd1 << 19,
        ST_DONE     = 21'd1 << 20
    } state_t;

    localparam logic [EW:0] EDGE_CAP = (EW+1)'(MAX_EDGES);
    localparam logic [EW:0] EONE     = (EW+1)'(1);
    localparam logic [VW:0] VONE     = (VW+1)'(1);

    state_t state_reg, state_next;
    logic [EW:0]   total_reg, total_next;
    logic          ovf_reg, ovf_next;
    logic [EW:0]   e_reg, e_next;
    logic [EW:0]   cnt_reg, cnt_next;
    logic [VW:0]   i_reg, i_next;
    vtag_t         s_reg, s_next;
    vtag_t         j_reg, j_next;
    logic [VW:0]   nv_reg, nv_next;
    logic [VW-1:0] root_reg, root_next;
    logic          first_reg, first_next;
    logic          found_reg, found_next;
    logic          unreach_reg, unreach_next;
    logic [AW-1:0] tree_reg, tree_next;
    logic [AW-1:0] contr_reg, contr_next;
    logic [VW-1:0] ea_reg, ea_next;
    logic [VW-1:0] eb_reg, eb_next;
    logic [CW-1:0] ec_reg, ec_next;
    vtag_t         rb_reg, rb_next;
    logic [CW-1:0] cb_reg, cb_next;

    logic          edge_we;
    logic [EW-1:0] edge_waddr, edge_raddr;
    mas_edge_t     edge_wdata, edge_q;
    logic          vi_we;
    logic [VW-1:0] vi_waddr, vi_raddr;
    mas_vinfo_t    vi_wdata, vi_q;
    logic          vis_we;
    logic [VW-1:0] vis_waddr, vis_raddr;
    vtag_t         vis_wdata, vis_q;
    logic          rep_we;
    logic [VW-1:0] rep_waddr, rep_raddr;
    vtag_t         rep_wdata, rep_q;
    logic          mrg_we;
    logic [VW-1:0] mrg_waddr, mrg_raddr;
    logic          mrg_wdata, mrg_q;

    // shared accumulator adder
    logic [AW-1:0] acc_sum;
    logic [AW:0]   final_sum;
    vtag_t         new_a, new_b;
    logic [CW-1:0] new_c;

    assign acc_sum   = ((state_reg == ST_CYC_UP) ? contr_reg : tree_reg) + AW'(vi_q.cost);
    assign final_sum = {1'b0, tree_reg} + {1'b0, contr_reg};
    assign new_b     = (rb_reg != NO_VERTEX) ? rb_reg : {1'b0, eb_reg};
    assign new_c     = (rb_reg != NO_VERTEX) ? (ec_reg - cb_reg) : ec_reg;
    assign new_a     = (rep_q != NO_VERTEX) ? rep_q : {1'b0, ea_reg};

    mas_ram #(.WIDTH($bits(mas_edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_q)
    );

    mas_ram #(.WIDTH($bits(mas_vinfo_t)), .DEPTH(MAX_VERTICES)) u_vinfo_ram (
        .aclk(aclk), .we(vi_we), .waddr(vi_waddr), .wdata(vi_wdata),
        .raddr(vi_raddr), .rdata(vi_q)
    );

    mas_ram #(.WIDTH(VW+1), .DEPTH(MAX_VERTICES)) u_visit_ram (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_q)
    );

    mas_ram #(.WIDTH(VW+1), .DEPTH(MAX_VERTICES)) u_rep_ram (
        .aclk(aclk), .we(rep_we), .waddr(rep_waddr), .wdata(rep_wdata),
        .raddr(rep_raddr), .rdata(rep_q)
    );

    mas_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_merged_ram (
        .aclk(aclk), .we(mrg_we), .waddr(mrg_waddr), .wdata(mrg_wdata),
        .raddr(mrg_raddr), .rdata(mrg_q)
    );

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        e_next       = e_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        s_next       = s_reg;
        j_next       = j_reg;
        nv_next      = nv_reg;
        root_next    = root_reg;
        first_next   = first_reg;
        found_next   = found_reg;
        unreach_next = unreach_reg;
        tree_next    = tree_reg;
        contr_next   = contr_reg;
        ea_next      = ea_reg;
        eb_next      = eb_reg;
        ec_next      = ec_reg;
        rb_next      = rb_reg;
        cb_next      = cb_reg;

        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = cmd.edge_rec;
        edge_raddr = e_reg[EW-1:0];
        vi_we      = 1'b0;
        vi_waddr   = i_reg[VW-1:0];
        vi_wdata   = '{src: NO_VERTEX, cost: '0};
        vi_raddr   = i_reg[VW-1:0];
        vis_we     = 1'b0;
        vis_waddr  = i_reg[VW-1:0];
        vis_wdata  = NO_VERTEX;
        vis_raddr  = s_reg[VW-1:0];
        rep_we     = 1'b0;
        rep_waddr  = i_reg[VW-1:0];
        rep_wdata  = NO_VERTEX;
        rep_raddr  = ea_reg;
        mrg_we     = 1'b0;
        mrg_waddr  = i_reg[VW-1:0];
        mrg_wdata  = 1'b0;
        mrg_raddr  = i_reg[VW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    if (total_reg < EDGE_CAP) begin
                        edge_we    = 1'b1;
                        edge_waddr = total_reg[EW-1:0];
                        total_next = total_reg + EONE;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                if (cmd.run) begin
                    nv_next    = cmd.nv;
                    root_next  = cmd.root;
                    e_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_FILT_RD;
                end
            end
            ST_FILT_RD: begin
                if (e_reg < total_reg) begin
                    state_next = ST_FILT_WR;
                end else begin
                    i_next     = '0;
                    first_next = 1'b1;
                    contr_next = '0;
                    state_next = ST_INIT;
                end
            end
            ST_FILT_WR: begin
                if ({1'b0, edge_q.src} < nv_reg && {1'b0, edge_q.dst} < nv_reg &&
                    edge_q.src != edge_q.dst) begin
                    edge_we    = 1'b1;
                    edge_waddr = cnt_reg[EW-1:0];
                    edge_wdata = edge_q;
                    cnt_next   = cnt_reg + EONE;
                end
                e_next     = e_reg + EONE;
                state_next = ST_FILT_RD;
            end
            ST_INIT: begin
                if (i_reg < nv_reg) begin
                    vi_we  = 1'b1;
                    vis_we = 1'b1;
                    rep_we = 1'b1;
                    mrg_we = first_reg;
                    i_next = i_reg + VONE;
                end else begin
                    e_next     = '0;
                    state_next = ST_MIN_RD;
                end
            end
            ST_MIN_RD: begin
                if (e_reg < cnt_reg) begin
                    state_next = ST_MIN_VR;
                end else begin
                    i_next     = '0;
                    tree_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_WALK_RD;
                end
            end
            ST_MIN_VR: begin
                ea_next    = edge_q.src;
                eb_next    = edge_q.dst;
                ec_next    = edge_q.cost;
                vi_raddr   = edge_q.dst;
                state_next = ST_MIN_UP;
            end
            ST_MIN_UP: begin
                if (eb_reg != root_reg &&
                    (vi_q.src == NO_VERTEX || ec_reg < vi_q.cost)) begin
                    vi_we    = 1'b1;
                    vi_waddr = eb_reg;
                    vi_wdata = '{src: {1'b0, ea_reg}, cost: ec_reg};
                end
                e_next     = e_reg + EONE;
                state_next = ST_MIN_RD;
            end
            ST_WALK_RD: begin
                if (i_reg < nv_reg) begin
                    state_next = ST_WALK_CHK;
                end else if (found_reg) begin
                    e_next     = '0;
                    state_next = ST_REW_RD;
                end else begin
                    unreach_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_WALK_CHK: begin
                if (mrg_q) begin
                    i_next     = i_reg + VONE;
                    state_next = ST_WALK_RD;
                end else if (vi_q.src == NO_VERTEX && i_reg != {1'b0, root_reg}) begin
                    unreach_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    if (vi_q.src != NO_VERTEX) begin
                        tree_next = acc_sum;
                    end
                    s_next     = i_reg;
                    state_next = ST_STEP_RD;
                end
            end
            ST_STEP_RD: begin
                if (s_reg == NO_VERTEX) begin
                    i_next     = i_reg + VONE;
                    state_next = ST_WALK_RD;
                end else begin
                    vi_raddr   = s_reg[VW-1:0];
                    state_next = ST_STEP_CHK;
                end
            end
            ST_STEP_CHK: begin
                if (vis_q == NO_VERTEX) begin
                    vis_we     = 1'b1;
                    vis_waddr  = s_reg[VW-1:0];
                    vis_wdata  = i_reg;
                    s_next     = vi_q.src;
                    state_next = ST_STEP_RD;
                end else if (vis_q == i_reg) begin
                    j_next     = s_reg;
                    found_next = 1'b1;
                    state_next = ST_CYC_RD;
                end else begin
                    i_next     = i_reg + VONE;
                    state_next = ST_WALK_RD;
                end
            end
            ST_CYC_RD: begin
                vi_raddr   = j_reg[VW-1:0];
                state_next = ST_CYC_UP;
            end
            ST_CYC_UP: begin
                rep_we     = 1'b1;
                rep_waddr  = j_reg[VW-1:0];
                rep_wdata  = s_reg;
                mrg_we     = 1'b1;
                mrg_waddr  = j_reg[VW-1:0];
                mrg_wdata  = 1'b1;
                contr_next = acc_sum;
                j_next     = vi_q.src;
                state_next = (vi_q.src == s_reg) ? ST_CYC_END : ST_CYC_RD;
            end
            ST_CYC_END: begin
                mrg_we     = 1'b1;
                mrg_waddr  = s_reg[VW-1:0];
                mrg_wdata  = 1'b0;
                i_next     = i_reg + VONE;
                state_next = ST_WALK_RD;
            end
            ST_REW_RD: begin
                if (e_reg < cnt_reg) begin
                    state_next = ST_REW_RB;
                end else begin
                    i_next     = '0;
                    first_next = 1'b0;
                    state_next = ST_INIT;
                end
            end
            ST_REW_RB: begin
                ea_next    = edge_q.src;
                eb_next    = edge_q.dst;
                ec_next    = edge_q.cost;
                rep_raddr  = edge_q.dst;
                vi_raddr   = edge_q.dst;
                state_next = ST_REW_RA;
            end
            ST_REW_RA: begin
                rb_next    = rep_q;
                cb_next    = vi_q.cost;
                state_next = ST_REW_UP;
            end
            ST_REW_UP: begin
                if (new_a == new_b) begin
                    cnt_next   = cnt_reg - EONE;
                    state_next = ST_COPY_RD;
                end else begin
                    edge_we    = 1'b1;
                    edge_waddr = e_reg[EW-1:0];
                    edge_wdata = '{src: new_a[VW-1:0], dst: new_b[VW-1:0], cost: new_c};
                    e_next     = e_reg + EONE;
                    state_next = ST_REW_RD;
                end
            end
            ST_COPY_RD: begin
                edge_raddr = cnt_reg[EW-1:0];
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                edge_we    = 1'b1;
                edge_waddr = e_reg[EW-1:0];
                edge_wdata = edge_q;
                state_next = ST_REW_RD;
            end
            ST_DONE: begin
                if (cmd.ack) begin
                    total_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg       <= e_next;
        cnt_reg     <= cnt_next;
        i_reg       <= i_next;
        s_reg       <= s_next;
        j_reg       <= j_next;
        nv_reg      <= nv_next;
        root_reg    <= root_next;
        first_reg   <= first_next;
        found_reg   <= found_next;
        unreach_reg <= unreach_next;
        tree_reg    <= tree_next;
        contr_reg   <= contr_next;
        ea_reg      <= ea_next;
        eb_reg      <= eb_next;
        ec_reg      <= ec_next;
        rb_reg      <= rb_next;
        cb_reg      <= cb_next;
    end

    assign st.idle                 = (state_reg == ST_IDLE);
    assign st.done                 = (state_reg == ST_DONE);
    assign st.result.total_weight  = unreach_reg ? '0 : final_sum[OW-1:0];
    assign st.result.unreachable   = unreach_reg;
    assign st.result.edges_dropped = ovf_reg;

    a_total_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= EDGE_CAP)
        else $error("edge count beyond capacity");

    a_cnt_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_FILT_RD) |-> cnt_reg <= total_reg)
        else $error("compacted edge count exceeds stored count");

    a_rew_needs_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REW_RB) |-> found_reg)
        else $error("reweight pass without a contracted cycle");

    a_ack_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ack |-> state_reg == ST_DONE)
        else $error("result taken while no solve finished");

endmodule

`default_nettype wire

// ===== rtl/core/min_arborescence_solver.sv =====
// ----------------------------------------------------------------------------
// min_arborescence_solver: minimum arborescence (Chu-Liu/Edmonds) solver
// Edge loads are stored one per cycle while the solver is idle; a solve returns the
// arborescence weight, an unreachable flag and a store overflow flag.
// ----------------------------------------------------------------------------
// Load transaction: back to back, no result.
// Solve transaction: compacts the edge store, then per round initialises the vertex
//   RAMs, picks each vertex's min in-edge, walks vertices to contract cycles, and
//   reweights edges, refilling each dropped edge's slot from the end of the store.
// One result register; loads are taken while a result waits, s_ready low in a solve.
// Reset (aresetn, synchronous, low): edge store empty, vertex_count = 1.
`default_nettype none

module min_arborescence_solver
    import mas_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire mas_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output mas_out_t         m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data
);

    logic [10:0] vcount_reg, vcount_next;
    logic        m_valid_reg, m_valid_next;
    mas_out_t    m_data_reg, m_data_next;
    mas_cmd_t    cmd;
    mas_stat_t   st;
    logic        take;

    assign take = s_valid && s_ready;

    always_comb begin
        cmd.load     = take && !s_data.req_type;
        cmd.run      = take && s_data.req_type;
        cmd.ack      = st.done && (!m_valid_reg || m_ready);
        cmd.edge_rec = '{src: s_data.edge_from, dst: s_data.edge_to,
                         cost: s_data.edge_weight};
        cmd.root     = s_data.root_vertex;
        cmd.nv       = (vcount_reg > 11'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES)
                                                       : (VW+1)'(vcount_reg);
    end

    always_comb begin
        vcount_next  = cfg_wr_en ? cfg_wr_data : vcount_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.ack) begin
            m_valid_next = 1'b1;
            m_data_next  = st.result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg  <= 11'd1;
            m_valid_reg <= 1'b0;
        end else begin
            vcount_reg  <= vcount_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    mas_engine u_engine (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd(cmd),
        .st(st)
    );

    assign s_ready = st.idle;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
